FILE: rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FM0_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define FM0_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FM0_ASSERT_RST(lbl, clk, rst_n, prop, msg)

`define FM0_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/fm0_pkg.sv
// types and constants of the fm0 bit detector with crc check
package fm0_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned ProdW   = 2 * SampleW + 1;
  localparam int unsigned SumW    = ProdW + 1;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CrcW    = 16;
  localparam int unsigned CntW    = 5;

  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly = 16'h1021;
  localparam logic [CntW-1:0] WinBits = 5'd16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHAN_RE  = 2'd0,
    CFG_CHAN_IM  = 2'd1,
    CFG_CRC_MODE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SampleW-1:0] first_re;
    logic signed [SampleW-1:0] first_im;
    logic signed [SampleW-1:0] second_re;
    logic signed [SampleW-1:0] second_im;
    logic                      last_symbol;
  } in_item_t;

  typedef struct packed {
    logic data_bit;
    logic frame_end;
    logic crc_ok;
  } out_item_t;

  typedef struct packed {
    logic signed [ProdW-1:0] prod_re;
    logic signed [ProdW-1:0] prod_im;
    logic                    last_symbol;
  } metric_t;

endpackage

FILE: rtl/fm0_metric.sv
// differential half-bit products against the channel estimate, registered
module fm0_metric import fm0_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  in_item_t                  item_i,
  input  logic signed [SampleW-1:0] chan_re_i,
  input  logic signed [SampleW-1:0] chan_im_i,
  output metric_t                   metric_o
);

  logic signed [SampleW:0] diff_re;
  logic signed [SampleW:0] diff_im;
  metric_t                 metric_d;
  metric_t                 metric_q;

  assign diff_re = (SampleW+1)'(item_i.first_re) - (SampleW+1)'(item_i.second_re);
  assign diff_im = (SampleW+1)'(item_i.first_im) - (SampleW+1)'(item_i.second_im);

  always_comb begin
    metric_d.prod_re     = ProdW'(diff_re) * ProdW'(chan_re_i);
    metric_d.prod_im     = ProdW'(diff_im) * ProdW'(chan_im_i);
    metric_d.last_symbol = item_i.last_symbol;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      metric_q <= metric_d;
    end
  end

  assign metric_o = metric_q;

endmodule

FILE: rtl/fm0_frame_check.sv
// phase decision, fm0 bit decode, delay window and crc-16 frame check
module fm0_frame_check import fm0_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      crc_mode_i,
  input  metric_t   metric_i,
  output out_item_t result_o
);

  logic                   phase_q;
  logic                   phase_d;
  logic [CrcW-1:0]        crc_q;
  logic [CrcW-1:0]        crc_d;
  logic [CrcW-1:0]        win_q;
  logic [CrcW-1:0]        win_d;
  logic [CntW-1:0]        cnt_q;
  logic [CntW-1:0]        cnt_d;
  logic signed [SumW-1:0] sum;
  logic                   phase;
  logic                   data_bit;
  logic                   was_full;
  logic                   fb;
  logic [CrcW-1:0]        crc_shift;
  logic [CrcW-1:0]        win_shift;
  logic                   crc_ok;

  assign sum      = SumW'(metric_i.prod_re) + SumW'(metric_i.prod_im);
  assign phase    = !sum[SumW-1] && (|sum);
  assign data_bit = phase ^ phase_q;
  assign was_full = (cnt_q == WinBits);
  assign fb       = crc_q[CrcW-1] ^ win_q[CrcW-1];

  always_comb begin
    crc_shift = was_full ? ({crc_q[CrcW-2:0], 1'b0} ^ (fb ? CrcPoly : '0)) : crc_q;
    win_shift = {win_q[CrcW-2:0], data_bit};
    crc_ok    = crc_mode_i && metric_i.last_symbol && was_full && (~crc_shift == win_shift);
  end

  // next frame state, cleared after the last bit of a frame
  always_comb begin
    phase_d = phase;
    crc_d   = crc_q;
    win_d   = win_q;
    cnt_d   = cnt_q;
    if (crc_mode_i) begin
      crc_d = crc_shift;
      win_d = win_shift;
      cnt_d = was_full ? cnt_q : cnt_q + 1'b1;
    end
    if (metric_i.last_symbol) begin
      phase_d = 1'b1;
      crc_d   = CrcInit;
      win_d   = '0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b1;
      crc_q   <= CrcInit;
      win_q   <= '0;
      cnt_q   <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      win_q   <= win_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    result_o.data_bit  = data_bit;
    result_o.frame_end = metric_i.last_symbol;
    result_o.crc_ok    = crc_ok;
  end

endmodule

FILE: rtl/fm0_bit_detect_crc_check.sv
// top level of the fm0 bit detector with crc-16 frame check
//
//   channel   direction   handshake                    item
//   in        to block    in_valid_i / in_stall_o      in_item_t
//   out       from block  out_valid_o / out_stall_i    out_item_t
//   cfg       to block    cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// one item per cycle unless out_stall_i stalls the flow; accepted items pass through
// the input, product and result registers before their results are valid
// differences and products of the metric lie between the input and product registers
// out_stall_i reaches in_stall_o combinationally through the three stage slots
// reset clears the frame state and sets the channel to zero and crc mode on
`include "assert_macros.svh"

module fm0_bit_detect_crc_check import fm0_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  logic signed [SampleW-1:0] chan_re_q;
  logic signed [SampleW-1:0] chan_im_q;
  logic                      crc_mode_q;

  in_item_t  in_item_q;
  logic      s1_valid_q;
  logic      s2_valid_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t result;
  metric_t   metric;
  logic      out_ready;
  logic      s2_ready;
  logic      s1_ready;
  logic      in_take;
  logic      s1_move;
  logic      s2_move;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s2_ready   = !s2_valid_q || out_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_take    = in_valid_i && s1_ready;
  assign s1_move    = s1_valid_q && s2_ready;
  assign s2_move    = s2_valid_q && out_ready;
  assign in_stall_o = !s1_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_re_q  <= '0;
      chan_im_q  <= '0;
      crc_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CHAN_RE:  chan_re_q  <= cfg_wdata_i[SampleW-1:0];
        CFG_CHAN_IM:  chan_im_q  <= cfg_wdata_i[SampleW-1:0];
        CFG_CRC_MODE: crc_mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      out_item_q <= result;
    end
  end

  fm0_metric u_metric (
    .clk_i     (clk_i),
    .en_i      (s1_move),
    .item_i    (in_item_q),
    .chan_re_i (chan_re_q),
    .chan_im_i (chan_im_q),
    .metric_o  (metric)
  );

  fm0_frame_check u_frame_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (s2_move),
    .crc_mode_i (crc_mode_q),
    .metric_i   (metric),
    .result_o   (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `FM0_ASSERT_RST(a_ok_needs_mode, clk_i, rst_ni, (s2_move && result.crc_ok) |-> (crc_mode_q && metric.last_symbol), "crc_ok outside a crc frame end")
  `FM0_ASSERT_RST(a_empty_takes, clk_i, rst_ni, !s1_valid_q |-> !in_stall_o, "input stalled with an empty input stage")
  `FM0_ASSERT_RST(a_full_stalls, clk_i, rst_ni, (s1_valid_q && s2_valid_q && out_valid_q && out_stall_i) |-> in_stall_o, "item taken with all stages full")
  `FM0_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> (!out_valid_o && !s2_valid_q), "pipeline not empty in reset")

endmodule

FILE: bench/fm0_frame_checker.sv
// checker that predicts the decoded bits and frame crc results and compares them with the block
module fm0_frame_checker import fm0_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  in_item_t           in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_item_t          out_item_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output int unsigned        err_count_o,
  output int unsigned        pending_o
);

  logic signed [SampleW-1:0] chan_re_q;
  logic signed [SampleW-1:0] chan_im_q;
  logic                      crc_mode_q;
  logic                      phase_q;
  logic [CrcW-1:0]           crc_q;
  logic [CrcW-1:0]           window_q;
  logic [CntW-1:0]           fill_q;
  out_item_t                 expected_bits[$];

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    err_count_o++;
  endtask

  task automatic clear_frame();
    phase_q  = 1'b1;
    crc_q    = CrcInit;
    window_q = '0;
    fill_q   = '0;
  endtask

  // metric is re((first - second) * conj(h)), exact in 64 bits
  function automatic logic phase_of(input in_item_t it);
    longint dr;
    longint di;
    longint m;
    dr = longint'($signed(it.first_re)) - longint'($signed(it.second_re));
    di = longint'($signed(it.first_im)) - longint'($signed(it.second_im));
    m  = dr * longint'(chan_re_q) + di * longint'(chan_im_q);
    return m > 0;
  endfunction

  task automatic decode_symbol(input in_item_t it);
    out_item_t want;
    logic      phase;
    logic      full;
    logic      fb;
    phase          = phase_of(it);
    want.data_bit  = phase ^ phase_q;
    want.frame_end = it.last_symbol;
    want.crc_ok    = 1'b0;
    phase_q        = phase;
    if (crc_mode_q) begin
      full = (fill_q >= WinBits);
      if (full) begin
        fb    = crc_q[CrcW-1] ^ window_q[CrcW-1];
        crc_q = {crc_q[CrcW-2:0], 1'b0} ^ (fb ? CrcPoly : CrcW'(0));
      end
      window_q = {window_q[CrcW-2:0], want.data_bit};
      if (!full) fill_q++;
      want.crc_ok = it.last_symbol && full && ((~crc_q) == window_q);
    end
    if (it.last_symbol) clear_frame();
    expected_bits.insert(expected_bits.size(), want);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_bits.size() == 0) begin
      report_mismatch($sformatf("result with no item pending: %b", got));
      return;
    end
    want = expected_bits.pop_front();
    if (got.data_bit !== want.data_bit)
      report_mismatch($sformatf("data_bit %b, expected %b", got.data_bit, want.data_bit));
    if (got.frame_end !== want.frame_end)
      report_mismatch($sformatf("frame_end %b, expected %b", got.frame_end, want.frame_end));
    if (got.crc_ok !== want.crc_ok)
      report_mismatch($sformatf("crc_ok %b, expected %b", got.crc_ok, want.crc_ok));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_re_q   = '0;
      chan_im_q   = '0;
      crc_mode_q  = 1'b1;
      clear_frame();
      expected_bits.delete();
      err_count_o = 0;
      pending_o   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_item_i);
      if (in_valid_i && !in_stall_i) decode_symbol(in_item_i);
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CHAN_RE:  chan_re_q  = cfg_wdata_i;
          CFG_CHAN_IM:  chan_im_q  = cfg_wdata_i;
          CFG_CRC_MODE: crc_mode_q = cfg_wdata_i[0];
          default: ;
        endcase
      end
      pending_o = expected_bits.size();
    end
  end

endmodule

FILE: bench/testbench.sv
// testbench top: clock, reset, fm0 symbol and frame stimulus, register writes and verdict
module testbench import fm0_pkg::*; ();

  localparam int NumPhases     = 5;
  localparam int PhaseItems    = 190;
  localparam int WatchdogLimit = 500;

  typedef logic bit_q_t[$];

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  in_item_t           in_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_item_t          out_item_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;
  int unsigned        err_count;
  int unsigned        pending;

  logic sender_idles;
  logic receiver_stalls;
  logic line_phase;
  int   chan_re_set;
  int   chan_im_set;
  int   symbols_sent;

  fm0_bit_detect_crc_check i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  fm0_frame_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic in_item_t make_item(input int fr, input int fi, input int sr,
                                         input int si, input logic last);
    in_item_t it;
    it.first_re    = SampleW'(fr);
    it.first_im    = SampleW'(fi);
    it.second_re   = SampleW'(sr);
    it.second_im   = SampleW'(si);
    it.last_symbol = last;
    return it;
  endfunction

  // first sample such that first - diff still fits the sample range
  function automatic int pick_first(input int diff);
    int lo;
    int hi;
    lo = (diff > 0) ? diff - 32768 : -32768;
    hi = (diff > 0) ? 32767 : 32767 + diff;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // random samples whose metric has the wanted sign under the current channel
  function automatic in_item_t symbol_for_phase(input logic want, input logic last);
    int dr;
    int di;
    int fr;
    int fi;
    dr = int'($urandom_range(1, 65535));
    di = int'($urandom_range(1, 65535));
    if ((chan_re_set < 0) == want) dr = -dr;
    if ((chan_im_set < 0) == want) di = -di;
    fr = pick_first(dr);
    fi = pick_first(di);
    return make_item(fr, fi, fr - dr, fi - di, last);
  endfunction

  function automatic bit_q_t random_bits(input int n);
    bit_q_t bits;
    for (int i = 0; i < n; i++) bits.insert(bits.size(), logic'($urandom_range(0, 1)));
    return bits;
  endfunction

  task automatic send_symbol(input in_item_t it);
    int gap;
    gap = sender_idles ? int'($urandom_range(0, 3)) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    symbols_sent++;
  endtask

  task automatic send_frame(input bit_q_t bits, input logic ends);
    for (int i = 0; i < bits.size(); i++) begin
      line_phase = line_phase ^ bits[i];
      send_symbol(symbol_for_phase(line_phase, ends && (i == bits.size() - 1)));
    end
    if (ends) line_phase = 1'b1;
  endtask

  task automatic send_crc_frame(input int n, input logic corrupt);
    bit_q_t          bits;
    logic [CrcW-1:0] crc;
    logic            fb;
    int              k;
    bits = random_bits(n);
    crc  = CrcInit;
    foreach (bits[i]) begin
      fb  = crc[CrcW-1] ^ bits[i];
      crc = {crc[CrcW-2:0], 1'b0} ^ (fb ? CrcPoly : CrcW'(0));
    end
    for (int j = CrcW - 1; j >= 0; j--) bits.insert(bits.size(), ~crc[j]);
    if (corrupt) begin
      k       = int'($urandom_range(0, bits.size() - 1));
      bits[k] = ~bits[k];
    end
    send_frame(bits, 1'b1);
  endtask

  task automatic send_noise_frame(input int n);
    for (int i = 0; i < n; i++)
      send_symbol(make_item($urandom, $urandom, $urandom, $urandom, i == n - 1));
    line_phase = 1'b1;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CfgW'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_CHAN_RE: chan_re_set = value;
      CFG_CHAN_IM: chan_im_set = value;
      default: ;
    endcase
  endtask

  // receiver: when receiver_stalls is set, may stall before taking each item
  initial begin
    int n;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      n = receiver_stalls ? int'($urandom_range(0, 3)) : 0;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int   hr;
    int   hi;
    int   pick;
    int   goal;
    logic mode;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_item_i       = '0;
    out_stall_i     = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    line_phase      = 1'b1;
    chan_re_set     = 0;
    chan_im_set     = 0;
    symbols_sent    = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero channel after reset: metric is always zero
    send_symbol(make_item(0, 0, 0, 0, 1'b0));
    send_symbol(make_item(32767, -32768, -32768, 32767, 1'b1));
    wait_drained();
    write_reg(CFG_CHAN_RE, 32767);
    write_reg(CFG_CHAN_IM, -32768);
    send_symbol(make_item(32767, -32768, -32768, 32767, 1'b0));
    send_symbol(make_item(-32768, 32767, 32767, -32768, 1'b0));
    // equal half-bits give a zero metric
    send_symbol(make_item(1234, -77, 1234, -77, 1'b1));
    send_crc_frame(1, 1'b0);
    // crc mode off and back on inside one frame
    send_frame(random_bits(3), 1'b0);
    wait_drained();
    write_reg(CFG_CRC_MODE, 0);
    send_frame(random_bits(2), 1'b0);
    wait_drained();
    write_reg(CFG_CRC_MODE, 1);
    send_frame(random_bits(2), 1'b1);

    for (int p = 0; p < NumPhases; p++) begin
      hr   = int'($urandom_range(0, 65535)) - 32768;
      hi   = int'($urandom_range(0, 65535)) - 32768;
      mode = 1'b1;
      case (p)
        0: begin hr = 32767;  hi = -32768; end
        1: begin hr = -32768; hi = 0;      end
        2: mode = 1'b0;
        3: begin hr = 0;      hi = 32767;  end
        default: ;
      endcase
      if (hr == 0 && hi == 0) hr = 1;
      wait_drained();
      write_reg(CFG_CHAN_RE, hr);
      write_reg(CFG_CHAN_IM, hi);
      write_reg(CFG_CRC_MODE, mode);
      sender_idles    = (p != 1);
      receiver_stalls = (p != 3);
      goal = symbols_sent + PhaseItems;
      while (symbols_sent < goal) begin
        pick = int'($urandom_range(0, 9));
        if (pick < 6)
          send_crc_frame(($urandom_range(0, 7) == 0) ? int'($urandom_range(17, 48))
                                                     : int'($urandom_range(1, 8)), 1'b0);
        else if (pick < 7)
          send_crc_frame(int'($urandom_range(1, 16)), 1'b1);
        else if (pick < 8)
          send_frame(random_bits(int'($urandom_range(1, 16))), 1'b1);
        else if (pick < 9)
          send_frame(random_bits(int'($urandom_range(17, 40))), 1'b1);
        else
          send_noise_frame(int'($urandom_range(1, 20)));
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
